### design/cop_pkg.sv
package cop_pkg;

   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } op_type;

   localparam int NUM_PIXELS = 8;
   localparam int IDX_BITS   = $clog2(NUM_PIXELS);

   typedef logic [IDX_BITS-1:0] pix_idx_type;

   localparam pix_idx_type LAST_IDX = pix_idx_type'(NUM_PIXELS - 1);

endpackage

### design/cop_octet.sv
module cop_octet #(
   parameter int COORD_BITS = 12
) (
   input  logic [COORD_BITS-1:0]        center_col,
   input  logic [COORD_BITS-1:0]        center_row,
   input  logic [COORD_BITS-1:0]        offset_x,
   input  logic [COORD_BITS-1:0]        offset_y,
   input  logic signed [COORD_BITS+3:0] decision,
   output logic signed [COORD_BITS+1:0] pixel_x [cop_pkg::NUM_PIXELS],
   output logic signed [COORD_BITS+1:0] pixel_y [cop_pkg::NUM_PIXELS],
   output logic [COORD_BITS-1:0]        offset_x_next,
   output logic [COORD_BITS-1:0]        offset_y_next,
   output logic signed [COORD_BITS+3:0] decision_next,
   output logic                         finished
);
   import cop_pkg::*;

   localparam int PIX_BITS = COORD_BITS + 2;
   localparam int DEC_BITS = COORD_BITS + 4;

   logic signed [PIX_BITS-1:0] cx, cy, xs, ys;
   logic signed [PIX_BITS-1:0] x_plus_one, y_after;
   logic signed [DEC_BITS-1:0] four_x, four_y;
   logic signed [PIX_BITS-1:0] cx_add_x, cx_sub_x, cy_add_y, cy_sub_y;
   logic signed [PIX_BITS-1:0] cx_add_y, cx_sub_y, cy_add_x, cy_sub_x;
   logic                       negative;

   assign cx = signed'({2'b00, center_col});
   assign cy = signed'({2'b00, center_row});
   assign xs = signed'({2'b00, offset_x});
   assign ys = signed'({2'b00, offset_y});

   assign four_x = signed'({2'b00, offset_x, 2'b00});
   assign four_y = signed'({2'b00, offset_y, 2'b00});

   assign negative = decision[DEC_BITS-1];

   always_comb begin
      if (negative) begin
         decision_next = decision + four_x + DEC_BITS'(6);
         y_after       = ys;
      end else begin
         decision_next = decision + four_x - four_y + DEC_BITS'(10);
         y_after       = ys - PIX_BITS'(1);
      end
   end

   assign x_plus_one    = xs + PIX_BITS'(1);
   assign finished      = !(x_plus_one < y_after);
   assign offset_x_next = offset_x + COORD_BITS'(1);
   assign offset_y_next = y_after[COORD_BITS-1:0];

   assign cx_add_x = cx + xs;
   assign cx_sub_x = cx - xs;
   assign cy_add_y = cy + ys;
   assign cy_sub_y = cy - ys;
   assign cx_add_y = cx + ys;
   assign cx_sub_y = cx - ys;
   assign cy_add_x = cy + xs;
   assign cy_sub_x = cy - xs;

   // The eight symmetric points, in the order they leave the block.
   always_comb begin
      pixel_x[0] = cx_add_x;  pixel_y[0] = cy_sub_y;
      pixel_x[1] = cx_sub_x;  pixel_y[1] = cy_sub_y;
      pixel_x[2] = cx_sub_x;  pixel_y[2] = cy_add_y;
      pixel_x[3] = cx_add_x;  pixel_y[3] = cy_add_y;
      pixel_x[4] = cx_sub_y;  pixel_y[4] = cy_add_x;
      pixel_x[5] = cx_sub_y;  pixel_y[5] = cy_sub_x;
      pixel_x[6] = cx_add_y;  pixel_y[6] = cy_sub_x;
      pixel_x[7] = cx_add_y;  pixel_y[7] = cy_add_x;
   end

endmodule

### design/circle_octant_point_generator.sv
// Midpoint circle rasterizer. A start item (tuser low) loads a center and a radius and
// yields the eight symmetric pixels of the top point; each step item (tuser high) yields
// the eight pixels of the next point, until the block flags the final pixel of the circle
// on rsp_tuser and falls idle. A step while idle yields nothing, and a start at any time
// begins a new circle. Each item passes an input register and is worked combinationally into
// an octet register, which drains one pixel per cycle while rsp_tready is high, with tlast
// on the eighth; the next item waits in the input register while an octet drains.
module circle_octant_point_generator #(
   parameter int COORD_BITS = 12
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // center_x, center_y, radius from the lowest bit up, zero filled to whole bytes
   input  logic [((3*COORD_BITS-1+7)/8)*8-1:0]    req_tdata,
   // operation
   input  cop_pkg::op_type                        req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // pixel_x, pixel_y from the lowest bit up, zero filled to whole bytes
   output logic [((2*(COORD_BITS+2)+7)/8)*8-1:0]  rsp_tdata,
   output logic                                   rsp_tlast,
   // circle_done
   output logic                                   rsp_tuser
);
   import cop_pkg::*;

   localparam int RAD_BITS      = COORD_BITS - 1;
   localparam int PIX_BITS      = COORD_BITS + 2;
   localparam int DEC_BITS      = COORD_BITS + 4;
   localparam int RSP_DATA_BITS = ((2*PIX_BITS+7)/8)*8;

   logic                  in_valid_ff, in_valid_in;
   op_type                in_op_ff, in_op_in;
   logic [COORD_BITS-1:0] in_cx_ff, in_cx_in;
   logic [COORD_BITS-1:0] in_cy_ff, in_cy_in;
   logic [RAD_BITS-1:0]   in_rad_ff, in_rad_in;

   logic                       active_ff, active_in;
   logic [COORD_BITS-1:0]      offset_x_ff, offset_x_in;
   logic [COORD_BITS-1:0]      offset_y_ff, offset_y_in;
   logic signed [DEC_BITS-1:0] decision_ff, decision_in;
   logic [COORD_BITS-1:0]      center_col_ff, center_col_in;
   logic [COORD_BITS-1:0]      center_row_ff, center_row_in;

   logic                       out_valid_ff, out_valid_in;
   pix_idx_type                idx_ff, idx_in;
   logic                       done_ff, done_in;
   logic signed [PIX_BITS-1:0] pix_x_ff [NUM_PIXELS];
   logic signed [PIX_BITS-1:0] pix_y_ff [NUM_PIXELS];

   logic                       is_start, advance, emit, last_taken, req_take;
   logic [COORD_BITS-1:0]      work_cx, work_cy, work_x, work_y;
   logic signed [DEC_BITS-1:0] work_p;
   logic signed [PIX_BITS-1:0] oct_x [NUM_PIXELS];
   logic signed [PIX_BITS-1:0] oct_y [NUM_PIXELS];
   logic [COORD_BITS-1:0]      next_x, next_y;
   logic signed [DEC_BITS-1:0] next_p;
   logic                       fin;

   assign last_taken = out_valid_ff && rsp_tready && (idx_ff == LAST_IDX);
   assign advance    = in_valid_ff && (!out_valid_ff || last_taken);
   assign is_start   = (in_op_ff == OP_START);
   assign emit       = advance && (is_start || active_ff);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      if (is_start) begin
         work_cx = in_cx_ff;
         work_cy = in_cy_ff;
         work_x  = '0;
         work_y  = COORD_BITS'(in_rad_ff);
         work_p  = signed'(DEC_BITS'(3)) - signed'({4'b0000, in_rad_ff, 1'b0});
      end else begin
         work_cx = center_col_ff;
         work_cy = center_row_ff;
         work_x  = offset_x_ff;
         work_y  = offset_y_ff;
         work_p  = decision_ff;
      end
   end

   cop_octet #(
      .COORD_BITS (COORD_BITS)
   ) u_octet (
      .center_col    (work_cx),
      .center_row    (work_cy),
      .offset_x      (work_x),
      .offset_y      (work_y),
      .decision      (work_p),
      .pixel_x       (oct_x),
      .pixel_y       (oct_y),
      .offset_x_next (next_x),
      .offset_y_next (next_y),
      .decision_next (next_p),
      .finished      (fin)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_op_in    = in_op_ff;
      in_cx_in    = in_cx_ff;
      in_cy_in    = in_cy_ff;
      in_rad_in   = in_rad_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_op_in    = req_tuser;
         in_cx_in    = req_tdata[COORD_BITS-1:0];
         in_cy_in    = req_tdata[2*COORD_BITS-1:COORD_BITS];
         in_rad_in   = req_tdata[3*COORD_BITS-2:2*COORD_BITS];
      end
   end

   always_comb begin
      active_in     = active_ff;
      offset_x_in   = offset_x_ff;
      offset_y_in   = offset_y_ff;
      decision_in   = decision_ff;
      center_col_in = center_col_ff;
      center_row_in = center_row_ff;
      done_in       = done_ff;
      if (emit) begin
         active_in     = !fin;
         offset_x_in   = next_x;
         offset_y_in   = next_y;
         decision_in   = next_p;
         center_col_in = work_cx;
         center_row_in = work_cy;
         done_in       = fin;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      idx_in       = idx_ff;
      if (out_valid_ff && rsp_tready) begin
         idx_in = idx_ff + pix_idx_type'(1);
         if (idx_ff == LAST_IDX) begin
            out_valid_in = 1'b0;
         end
      end
      if (emit) begin
         out_valid_in = 1'b1;
         idx_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      in_op_ff      <= in_op_in;
      in_cx_ff      <= in_cx_in;
      in_cy_ff      <= in_cy_in;
      in_rad_ff     <= in_rad_in;
      offset_x_ff   <= offset_x_in;
      offset_y_ff   <= offset_y_in;
      decision_ff   <= decision_in;
      center_col_ff <= center_col_in;
      center_row_ff <= center_row_in;
      done_ff       <= done_in;
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         pix_x_ff <= oct_x;
         pix_y_ff <= oct_y;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({pix_y_ff[idx_ff], pix_x_ff[idx_ff]});
   assign rsp_tlast  = (idx_ff == LAST_IDX);
   assign rsp_tuser  = done_ff && (idx_ff == LAST_IDX);

endmodule

### tb/circle_octant_point_generator_tb.sv
module circle_octant_point_generator_tb;
   import cop_pkg::*;

   localparam int COORD_BITS = 12;
   localparam int RAD_BITS = COORD_BITS - 1;
   localparam int PIX_W = COORD_BITS + 2;
   localparam int DEC_W = COORD_BITS + 4;
   localparam int REQ_W = ((3*COORD_BITS-1+7)/8)*8;
   localparam int RSP_W = ((2*(COORD_BITS+2)+7)/8)*8;
   localparam int RANDOM_ITEMS = 290;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DIRECTED_ROWS = 22;

   typedef enum logic [1:0] {
      BY_MODEL,
      NO_PIXELS,
      ALL_AT_CENTER
   } check_kind_type;

   typedef struct packed {
      op_type                op;
      logic [COORD_BITS-1:0] cx;
      logic [COORD_BITS-1:0] cy;
      logic [RAD_BITS-1:0]   rad;
      check_kind_type        chk;
   } stim_row_type;

   typedef struct packed {
      logic [PIX_W-1:0] px;
      logic [PIX_W-1:0] py;
      logic             last;
      logic             done;
   } pixel_rec_type;

   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{OP_STEP,  12'h000, 12'h000, 11'h000, NO_PIXELS},
      '{OP_START, 12'h000, 12'h000, 11'h000, ALL_AT_CENTER},
      '{OP_STEP,  12'h000, 12'h000, 11'h000, NO_PIXELS},
      '{OP_START, 12'hfff, 12'hfff, 11'h000, ALL_AT_CENTER},
      '{OP_STEP,  12'hfff, 12'hfff, 11'h7ff, NO_PIXELS},
      '{OP_START, 12'h800, 12'h800, 11'h001, BY_MODEL},
      '{OP_START, 12'h000, 12'h000, 11'h7ff, BY_MODEL},
      '{OP_STEP,  12'h123, 12'h456, 11'h001, BY_MODEL},
      '{OP_STEP,  12'h000, 12'h000, 11'h000, BY_MODEL},
      '{OP_START, 12'hfff, 12'hfff, 11'h7ff, BY_MODEL},
      '{OP_STEP,  12'h000, 12'h000, 11'h000, BY_MODEL},
      '{OP_START, 12'haaa, 12'h555, 11'h555, BY_MODEL},
      '{OP_START, 12'h555, 12'haaa, 11'h2aa, BY_MODEL},
      '{OP_START, 12'hfff, 12'h000, 11'h005, BY_MODEL},
      '{OP_STEP,  12'h000, 12'h000, 11'h000, BY_MODEL},
      '{OP_STEP,  12'h000, 12'h000, 11'h000, BY_MODEL},
      '{OP_STEP,  12'h000, 12'h000, 11'h000, BY_MODEL},
      '{OP_STEP,  12'h000, 12'h000, 11'h000, BY_MODEL},
      '{OP_STEP,  12'h000, 12'h000, 11'h000, BY_MODEL},
      '{OP_START, 12'h7ff, 12'h000, 11'h002, BY_MODEL},
      '{OP_STEP,  12'h000, 12'h000, 11'h000, BY_MODEL},
      '{OP_STEP,  12'h000, 12'h000, 11'h000, BY_MODEL}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   op_type req_tuser = OP_START;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic rsp_tuser;

   logic [COORD_BITS-1:0] ring_col = '0;
   logic [COORD_BITS-1:0] ring_row = '0;
   logic [COORD_BITS-1:0] step_x = '0;
   logic [COORD_BITS-1:0] step_y = '0;
   logic signed [DEC_W-1:0] decision = '0;
   logic drawing = 1'b0;

   pixel_rec_type octet_pixels [8];
   pixel_rec_type pending_pixels [$];
   int mismatches = 0;
   int stall_left = 0;
   int quiet_cycles = 0;
   logic steady = 1'b0;

   circle_octant_point_generator #(
      .COORD_BITS(COORD_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         return 0;
      end else if (pick < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 30);
   endfunction

   function automatic logic [RAD_BITS-1:0] pick_radius();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
         return RAD_BITS'($urandom_range(0, 24));
      end else if (pick < 95) begin
         return RAD_BITS'($urandom_range(25, 200));
      end
      return RAD_BITS'($urandom_range(201, 2047));
   endfunction

   function automatic pixel_rec_type make_pixel(input int px, input int py, input logic last,
                                                input logic done);
      return {PIX_W'(px), PIX_W'(py), last, done};
   endfunction

   // Emits the octet of the current point, then moves the point along the arc.
   task automatic rasterize_octet(input op_type op, input logic [COORD_BITS-1:0] cx,
                                  input logic [COORD_BITS-1:0] cy,
                                  input logic [RAD_BITS-1:0] rad, output int count);
      int x, y, y0, p, cc, cr;
      logic fin;
      count = 0;
      if (op == OP_START) begin
         ring_col = cx;
         ring_row = cy;
         step_x = '0;
         step_y = COORD_BITS'(rad);
         decision = DEC_W'(3 - 2*int'(rad));
         drawing = 1'b1;
      end
      if (drawing) begin
         cc = int'(ring_col);
         cr = int'(ring_row);
         x = int'(step_x);
         y0 = int'(step_y);
         y = y0;
         p = int'(decision);
         if (p < 0) begin
            p = p + 4*x + 6;
         end else begin
            p = p + 4*(x - y) + 10;
            y = y - 1;
         end
         fin = !((x + 1) < y);
         octet_pixels[0] = make_pixel(cc + x, cr - y0, 1'b0, 1'b0);
         octet_pixels[1] = make_pixel(cc - x, cr - y0, 1'b0, 1'b0);
         octet_pixels[2] = make_pixel(cc - x, cr + y0, 1'b0, 1'b0);
         octet_pixels[3] = make_pixel(cc + x, cr + y0, 1'b0, 1'b0);
         octet_pixels[4] = make_pixel(cc - y0, cr + x, 1'b0, 1'b0);
         octet_pixels[5] = make_pixel(cc - y0, cr - x, 1'b0, 1'b0);
         octet_pixels[6] = make_pixel(cc + y0, cr - x, 1'b0, 1'b0);
         octet_pixels[7] = make_pixel(cc + y0, cr + x, 1'b1, fin);
         step_x = COORD_BITS'(x + 1);
         step_y = COORD_BITS'(y);
         decision = DEC_W'(p);
         if (fin) begin
            drawing = 1'b0;
         end
         count = 8;
      end
   endtask

   task automatic send_item(input op_type op, input logic [COORD_BITS-1:0] cx,
                            input logic [COORD_BITS-1:0] cy,
                            input logic [RAD_BITS-1:0] rad, input check_kind_type chk,
                            output int count);
      int gap;
      gap = steady ? 0 : gap_len();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= REQ_W'({rad, cy, cx});
      do @(posedge clock); while (req_tready !== 1'b1);
      rasterize_octet(op, cx, cy, rad, count);
      case (chk)
         BY_MODEL: begin
            for (int k = 0; k < count; k++) pending_pixels.push_back(octet_pixels[k]);
         end
         ALL_AT_CENTER: begin
            for (int k = 0; k < 8; k++) begin
               pending_pixels.push_back(make_pixel(int'(cx), int'(cy), k == 7, k == 7));
            end
         end
         default: begin
         end
      endcase
      @(negedge clock);
   endtask

   task automatic drain_pixels();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_pixels.size() != 0) @(negedge clock);
   endtask

   task automatic flag_pixel(input string why, input pixel_rec_type want,
                             input pixel_rec_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s: expected x=%0d y=%0d last=%0b done=%0b, got x=%0d y=%0d last=%0b done=%0b",
                  why, $signed(want.px), $signed(want.py), want.last, want.done,
                  $signed(got.px), $signed(got.py), got.last, got.done);
      end
   endtask

   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!steady && $urandom_range(0, 3) == 0) begin
            stall_left <= gap_len();
         end
      end
   end

   always @(posedge clock) begin : collect_pixel
      pixel_rec_type got;
      pixel_rec_type want;
      got = {rsp_tdata[PIX_W-1:0], rsp_tdata[2*PIX_W-1:PIX_W], rsp_tlast, rsp_tuser};
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            flag_pixel("unexpected item", '0, got);
         end else begin
            want = pending_pixels.pop_front();
            if (got.px !== want.px || got.py !== want.py || got.last !== want.last ||
                got.done !== want.done) begin
               flag_pixel("item mismatch", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("circle_octant_point_generator_tb NOT OK");
         $finish;
      end
   end

   initial begin : stimulus
      int count;
      int produced;
      op_type op;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         send_item(DIRECTED[row].op, DIRECTED[row].cx, DIRECTED[row].cy, DIRECTED[row].rad,
                   DIRECTED[row].chk, count);
      end
      drain_pixels();

      produced = 0;
      while (produced < RANDOM_ITEMS) begin
         if ($urandom_range(0, 39) == 0) begin
            steady = !steady;
         end
         if ($urandom_range(0, 59) == 0) begin
            drain_pixels();
         end
         if (drawing) begin
            op = ($urandom_range(0, 29) == 0) ? OP_START : OP_STEP;
         end else begin
            op = ($urandom_range(0, 5) == 0) ? OP_STEP : OP_START;
         end
         send_item(op, COORD_BITS'($urandom), COORD_BITS'($urandom), pick_radius(), BY_MODEL,
                   count);
         if (count != 0) begin
            produced++;
         end
      end

      drain_pixels();
      repeat (20) @(negedge clock);
      if (mismatches == 0) begin
         $display("circle_octant_point_generator_tb OK");
      end else begin
         $display("circle_octant_point_generator_tb NOT OK");
      end
      $finish;
   end

endmodule
